/* hdl/mm3_pkg.sv */
package mm3_pkg;

    // Field widths of the message and digest channels.
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 3;

    // Bytes carried by one full message word.
    localparam logic [COUNT_W-1:0] BYTES_PER_WORD = 3'd4;

    // Default depth of the queue between the front and back ends.
    localparam int QUEUE_DEPTH = 4;

    // Scramble, fold and avalanche constants.
    localparam logic [WORD_W-1:0] SCR_MUL_A  = 32'hcc9e2d51;
    localparam logic [WORD_W-1:0] SCR_MUL_B  = 32'h1b873593;
    localparam logic [WORD_W-1:0] FOLD_ADD   = 32'he6546b64;
    localparam logic [WORD_W-1:0] AVAL_MUL_A = 32'h85ebca6b;
    localparam logic [WORD_W-1:0] AVAL_MUL_B = 32'hc2b2ae35;

    // How the back end treats a word.
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_TAIL = 2'd1,
        KIND_FULL = 2'd2
    } word_kind_t;

    // One classified, scrambled word waiting for the back end.
    typedef struct packed {
        logic [WORD_W-1:0]  key;
        word_kind_t         kind;
        logic [COUNT_W-1:0] count;
        logic               last;
        logic [WORD_W-1:0]  seed;
    } queue_entry_t;

    // Queue occupancy flags.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Back end activity flags.
    typedef struct packed {
        logic busy;
        logic emit;
    } back_status_t;

    // Rotate left by 15.
    function automatic logic [WORD_W-1:0] rotl15(input logic [WORD_W-1:0] x);
        return {x[WORD_W-16:0], x[WORD_W-1:WORD_W-15]};
    endfunction

    // Rotate left by 13.
    function automatic logic [WORD_W-1:0] rotl13(input logic [WORD_W-1:0] x);
        return {x[WORD_W-14:0], x[WORD_W-1:WORD_W-13]};
    endfunction

endpackage

/* hdl/mm3_in_if.sv */
interface mm3_in_if;
    logic                          valid;
    logic                          ready;
    logic [mm3_pkg::WORD_W-1:0]    word;
    logic [mm3_pkg::COUNT_W-1:0]   byte_count;
    logic                          last;
    logic [mm3_pkg::WORD_W-1:0]    seed;

    modport source (output valid, word, byte_count, last, seed, input ready);
    modport sink (input valid, word, byte_count, last, seed, output ready);
endinterface

/* hdl/mm3_out_if.sv */
interface mm3_out_if;
    logic                       valid;
    logic                       ready;
    logic [mm3_pkg::WORD_W-1:0] digest;

    modport source (output valid, digest, input ready);
    modport sink (input valid, digest, output ready);
endinterface

/* hdl/mm3_front.sv */
module mm3_front (
    input  logic                  clk,
    input  logic                  rst_n,
    mm3_in_if.sink                msg,
    output logic                  q_push,
    output mm3_pkg::queue_entry_t q_entry,
    input  mm3_pkg::queue_status_t q_stat
);

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic [mm3_pkg::WORD_W-1:0]    s1_key_reg;
    mm3_pkg::word_kind_t           s1_kind_reg;
    logic [mm3_pkg::COUNT_W-1:0]   s1_count_reg;
    logic                          s1_last_reg;
    logic [mm3_pkg::WORD_W-1:0]    s1_seed_reg;

    logic [mm3_pkg::COUNT_W-1:0]   count_eff;
    mm3_pkg::word_kind_t           kind;
    logic [mm3_pkg::WORD_W-1:0]    mask;
    logic                          accept;

    // Effective byte count: non-last words and oversize counts are full words.
    always_comb
    begin
        if (!msg.last || (msg.byte_count > mm3_pkg::BYTES_PER_WORD))
        begin
            count_eff = mm3_pkg::BYTES_PER_WORD;
        end
        else
        begin
            count_eff = msg.byte_count;
        end
    end

    // Classify the word and build the tail byte mask.
    always_comb
    begin
        case (count_eff)
            3'd0:
            begin
                kind = mm3_pkg::KIND_NONE;
                mask = 32'h0000_0000;
            end
            3'd1:
            begin
                kind = mm3_pkg::KIND_TAIL;
                mask = 32'h0000_00ff;
            end
            3'd2:
            begin
                kind = mm3_pkg::KIND_TAIL;
                mask = 32'h0000_ffff;
            end
            3'd3:
            begin
                kind = mm3_pkg::KIND_TAIL;
                mask = 32'h00ff_ffff;
            end
            default:
            begin
                kind = mm3_pkg::KIND_FULL;
                mask = 32'hffff_ffff;
            end
        endcase
    end

    // The first stage drains into the queue whenever the queue has room.
    assign q_push    = s1_valid_reg && !q_stat.full;
    assign msg.ready = !s1_valid_reg || !q_stat.full;
    assign accept    = msg.valid && msg.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // First scramble multiply, registered.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_key_reg   <= (msg.word & mask) * mm3_pkg::SCR_MUL_A;
            s1_kind_reg  <= kind;
            s1_count_reg <= count_eff;
            s1_last_reg  <= msg.last;
            s1_seed_reg  <= msg.seed;
        end
    end

    // Rotate and second scramble multiply; the queue entry is the register after it.
    always_comb
    begin
        q_entry.key   = mm3_pkg::rotl15(s1_key_reg) * mm3_pkg::SCR_MUL_B;
        q_entry.kind  = s1_kind_reg;
        q_entry.count = s1_count_reg;
        q_entry.last  = s1_last_reg;
        q_entry.seed  = s1_seed_reg;
    end

endmodule

/* hdl/mm3_fifo.sv */
module mm3_fifo #(
    parameter int DEPTH = mm3_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  mm3_pkg::queue_entry_t  push_entry,
    input  logic                   pop,
    output mm3_pkg::queue_entry_t  head,
    output mm3_pkg::queue_status_t stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mm3_pkg::queue_entry_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign head       = mem[rd_ptr_reg];

    // Pointer wrap and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* hdl/mm3_back.sv */
module mm3_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mm3_pkg::queue_entry_t  q_head,
    input  mm3_pkg::queue_status_t q_stat,
    output logic                   q_pop,
    mm3_out_if.source              hash,
    output mm3_pkg::back_status_t  bk_stat
);

    typedef enum logic [3:0] {
        ST_RUN   = 4'b0001,
        ST_MIX_A = 4'b0010,
        ST_MIX_B = 4'b0100,
        ST_EMIT  = 4'b1000
    } back_state_t;

    back_state_t                state_reg;
    back_state_t                state_next;
    logic [mm3_pkg::WORD_W-1:0] hash_reg;
    logic [mm3_pkg::WORD_W-1:0] hash_next;
    logic [mm3_pkg::WORD_W-1:0] total_reg;
    logic [mm3_pkg::WORD_W-1:0] total_next;
    logic                       mid_reg;
    logic                       mid_next;
    logic [mm3_pkg::WORD_W-1:0] mix_reg;
    logic [mm3_pkg::WORD_W-1:0] mix_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [mm3_pkg::WORD_W-1:0] digest_reg;
    logic [mm3_pkg::WORD_W-1:0] digest_next;

    logic [mm3_pkg::WORD_W-1:0] base;
    logic [mm3_pkg::WORD_W-1:0] total_base;
    logic [mm3_pkg::WORD_W-1:0] total_sum;
    logic [mm3_pkg::WORD_W-1:0] mixed_in;
    logic [mm3_pkg::WORD_W-1:0] rotated;
    logic [mm3_pkg::WORD_W-1:0] folded;
    logic                       emit;

    assign q_pop        = (state_reg == ST_RUN) && !q_stat.empty;
    assign emit         = (state_reg == ST_EMIT) && (!out_valid_reg || hash.ready);
    assign bk_stat.busy = (state_reg != ST_RUN);
    assign bk_stat.emit = emit;
    assign hash.valid   = out_valid_reg;
    assign hash.digest  = digest_reg;

    // Data step: a new message starts from the seed with a zero byte total.
    always_comb
    begin
        base       = mid_reg ? hash_reg : q_head.seed;
        total_base = mid_reg ? total_reg : '0;
        total_sum  = total_base + {{(mm3_pkg::WORD_W - mm3_pkg::COUNT_W){1'b0}}, q_head.count};
        mixed_in   = base ^ q_head.key;
        rotated    = mm3_pkg::rotl13(mixed_in);
        case (q_head.kind)
            mm3_pkg::KIND_FULL:
            begin
                folded = (rotated << 2) + rotated + mm3_pkg::FOLD_ADD;
            end
            mm3_pkg::KIND_TAIL:
            begin
                folded = mixed_in;
            end
            default:
            begin
                folded = base;
            end
        endcase
    end

    // Sequencer: fold words, then run the avalanche through ST_MIX_A, ST_MIX_B and ST_EMIT.
    always_comb
    begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        total_next     = total_reg;
        mid_next       = mid_reg;
        mix_next       = mix_reg;
        out_valid_next = out_valid_reg;
        digest_next    = digest_reg;

        if (out_valid_reg && hash.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_RUN:
            begin
                if (q_pop)
                begin
                    if (q_head.last)
                    begin
                        mix_next   = folded ^ total_sum;
                        hash_next  = '0;
                        total_next = '0;
                        mid_next   = 1'b0;
                        state_next = ST_MIX_A;
                    end
                    else
                    begin
                        hash_next  = folded;
                        total_next = total_sum;
                        mid_next   = 1'b1;
                    end
                end
            end
            ST_MIX_A:
            begin
                mix_next   = (mix_reg ^ (mix_reg >> 16)) * mm3_pkg::AVAL_MUL_A;
                state_next = ST_MIX_B;
            end
            ST_MIX_B:
            begin
                mix_next   = (mix_reg ^ (mix_reg >> 13)) * mm3_pkg::AVAL_MUL_B;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    digest_next    = mix_reg ^ (mix_reg >> 16);
                    out_valid_next = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            hash_reg      <= '0;
            total_reg     <= '0;
            mid_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            total_reg     <= total_next;
            mid_reg       <= mid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mix_reg    <= mix_next;
        digest_reg <= digest_next;
    end

endmodule

/* hdl/murmur3_32_stream_hash.sv */
// Streaming 32-bit MurmurHash3 (x86 variant).
// Channel msg carries one request per message word: word (little-endian, first
// byte in bits 7:0), byte_count, last and seed. The seed is taken from the
// first word of each message. Only the last word may carry fewer than four
// bytes; a last word with zero bytes just closes the message.
// Channel hash carries one request per message: the finished digest.
// Non-last words are taken at one per cycle while the queue has room. A
// scramble pipeline of two multiplies feeds a small queue, and the back end
// folds one queued word per cycle while in ST_RUN. A last word holds the
// back end through ST_MIX_A, ST_MIX_B and ST_EMIT, since the avalanche runs
// its two multiplies in series; the front keeps accepting words meanwhile
// until the queue fills. A last word passes the first-stage register, the
// queue, the fold in ST_RUN, the avalanche and the output register.
// When the receiver stalls, the digest holds in the output register, the back
// end waits with the next digest ready, the queue fills and msg.ready drops.
// Reset clears the queue, the running hash and the output; a message in
// flight is dropped and the next word starts a new message.
module murmur3_32_stream_hash #(
    parameter int QUEUE_DEPTH = mm3_pkg::QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    mm3_in_if.sink    msg,
    mm3_out_if.source hash
);

    logic                   q_push;
    logic                   q_pop;
    mm3_pkg::queue_entry_t  q_in;
    mm3_pkg::queue_entry_t  q_head;
    mm3_pkg::queue_status_t q_stat;
    mm3_pkg::back_status_t  bk_stat;

    // Classification and key scramble.
    mm3_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .msg     (msg),
        .q_push  (q_push),
        .q_entry (q_in),
        .q_stat  (q_stat)
    );

    // Decoupling queue.
    mm3_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    // Hash fold, avalanche and output register.
    mm3_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_head  (q_head),
        .q_stat  (q_stat),
        .q_pop   (q_pop),
        .hash    (hash),
        .bk_stat (bk_stat)
    );

`ifndef NO_ASSERTIONS
    // The front end never writes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_stat.full))
        else $error("queue written while full");

    // The back end never reads from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(q_pop && q_stat.empty))
        else $error("queue read while empty");

    // A new digest appears only after the back end finished an avalanche.
    assert property (@(posedge clk) disable iff (!rst_n) $rose(hash.valid) |-> $past(bk_stat.emit))
        else $error("digest presented without a finished avalanche");
`endif

endmodule
